// ===== sv/mfe_pkg.sv =====
package mfe_pkg;

  typedef enum logic [1:0] {
    MODE_RTU   = 2'd0,
    MODE_TCP   = 2'd1,
    MODE_ASCII = 2'd2
  } mode_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic       ADDR_FRAME_MODE = 1'b0;
  localparam int         PADDR_W         = 3;
  localparam int         QUEUE_DEPTH     = 2;
  localparam logic [1:0] FRAME_MODE_RST  = 2'd0;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  CHAR_COLON = 8'h3A;
  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [7:0]  BYTE_ZERO  = 8'h00;

  localparam logic [2:0] TCP_START_LEN = 3'd7;

  typedef struct packed {
    mode_t       mode;
    logic        is_start;
    logic        closes;
    logic [7:0]  b0;
    logic [15:0] tid;
    logic        ml_hi;
    logic [7:0]  ml_lo;
    logic [15:0] crc;
    logic [7:0]  lrc;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

endpackage

// ===== sv/mfe_in_if.sv =====
interface mfe_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  station_id;
  logic [15:0] transaction_id;
  logic [7:0]  pdu_length;
  logic [7:0]  data_byte;

  modport source (output valid, command, station_id, transaction_id, pdu_length, data_byte,
                  input ready);
  modport sink (input valid, command, station_id, transaction_id, pdu_length, data_byte,
                output ready);
endinterface

// ===== sv/mfe_out_if.sv =====
interface mfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;
  logic       end_of_run;

  modport source (output valid, frame_byte, end_of_frame, end_of_run, input ready);
  modport sink (input valid, frame_byte, end_of_frame, end_of_run, output ready);
endinterface

// ===== sv/mfe_front.sv =====
module mfe_front
  import mfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  frame_mode,
  mfe_in_if.sink      req,
  input  q_stat_t     q_stat,
  output logic        push,
  output job_t        push_job
);

  logic [15:0] crc_accum, crc_accum_next;
  logic [7:0]  lrc_sum, lrc_sum_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic        frame_open, frame_open_next;
  logic        accept;
  logic [8:0]  ml;
  mode_t       mode;

  assign req.ready = !q_stat.full;
  assign accept    = req.valid && req.ready;
  assign ml        = {1'b0, req.pdu_length} + 9'd1;

  always_comb begin
    case (frame_mode)
      MODE_TCP:   mode = MODE_TCP;
      MODE_ASCII: mode = MODE_ASCII;
      default:    mode = MODE_RTU;
    endcase
  end

  always_comb begin
    crc_accum_next  = crc_accum;
    lrc_sum_next    = lrc_sum;
    bytes_left_next = bytes_left;
    frame_open_next = frame_open;
    push            = 1'b0;
    if (accept) begin
      if (req.command == CMD_START) begin
        crc_accum_next  = crc_update(CRC_INIT, req.station_id);
        lrc_sum_next    = req.station_id;
        bytes_left_next = req.pdu_length;
        frame_open_next = (req.pdu_length != 8'd0);
        push            = 1'b1;
      end else if (frame_open) begin
        crc_accum_next  = crc_update(crc_accum, req.data_byte);
        lrc_sum_next    = lrc_sum + req.data_byte;
        bytes_left_next = bytes_left - 8'd1;
        frame_open_next = (bytes_left_next != 8'd0);
        push            = 1'b1;
      end
    end
  end

  always_comb begin
    push_job.mode     = mode;
    push_job.is_start = (req.command == CMD_START);
    push_job.closes   = !frame_open_next;
    push_job.b0       = (req.command == CMD_START) ? req.station_id : req.data_byte;
    push_job.tid      = req.transaction_id;
    push_job.ml_hi    = ml[8];
    push_job.ml_lo    = ml[7:0];
    push_job.crc      = crc_accum_next;
    push_job.lrc      = 8'd0 - lrc_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum  <= CRC_INIT;
      lrc_sum    <= 8'd0;
      bytes_left <= 8'd0;
      frame_open <= 1'b0;
    end else begin
      crc_accum  <= crc_accum_next;
      lrc_sum    <= lrc_sum_next;
      bytes_left <= bytes_left_next;
      frame_open <= frame_open_next;
    end
  end

endmodule

// ===== sv/mfe_queue.sv =====
module mfe_queue
  import mfe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/mfe_back.sv =====
module mfe_back
  import mfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  job_t     head,
  input  q_stat_t  q_stat,
  output logic     pop,
  mfe_out_if.source frm
);

  logic [2:0] idx;
  logic [2:0] n;
  logic [2:0] pos;
  logic [7:0] cur_byte;
  logic       last;
  logic       load;

  assign load = !q_stat.empty && (!frm.valid || frm.ready);
  assign last = (idx == n - 3'd1);
  assign pop  = load && last;
  assign pos  = head.is_start ? idx - 3'd1 : idx;

  always_comb begin
    case (head.mode)
      MODE_TCP:   n = head.is_start ? TCP_START_LEN : 3'd1;
      MODE_ASCII: n = (head.is_start ? 3'd3 : 3'd2) + (head.closes ? 3'd4 : 3'd0);
      default:    n = head.closes ? 3'd3 : 3'd1;
    endcase
  end

  always_comb begin
    case (head.mode)
      MODE_TCP: begin
        if (head.is_start) begin
          case (idx)
            3'd0:    cur_byte = head.tid[15:8];
            3'd1:    cur_byte = head.tid[7:0];
            3'd2:    cur_byte = BYTE_ZERO;
            3'd3:    cur_byte = BYTE_ZERO;
            3'd4:    cur_byte = {7'd0, head.ml_hi};
            3'd5:    cur_byte = head.ml_lo;
            default: cur_byte = head.b0;
          endcase
        end else begin
          cur_byte = head.b0;
        end
      end
      MODE_ASCII: begin
        if (head.is_start && idx == 3'd0) begin
          cur_byte = CHAR_COLON;
        end else begin
          case (pos)
            3'd0:    cur_byte = hex_char(head.b0[7:4]);
            3'd1:    cur_byte = hex_char(head.b0[3:0]);
            3'd2:    cur_byte = hex_char(head.lrc[7:4]);
            3'd3:    cur_byte = hex_char(head.lrc[3:0]);
            3'd4:    cur_byte = CHAR_CR;
            default: cur_byte = CHAR_LF;
          endcase
        end
      end
      default: begin
        case (idx)
          3'd0:    cur_byte = head.b0;
          3'd1:    cur_byte = head.crc[7:0];
          default: cur_byte = head.crc[15:8];
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      frm.valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= last ? 3'd0 : idx + 3'd1;
        frm.valid <= 1'b1;
      end else if (frm.ready) begin
        frm.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frm.frame_byte   <= cur_byte;
      frm.end_of_frame <= last && head.closes;
      frm.end_of_run   <= last;
    end
  end

endmodule

// ===== sv/modbus_frame_encoder.sv =====
// Modbus frame encoder. Items arrive on req: a start beat (command 0) opens a frame
// with station id, transaction id and PDU length, and each data beat (command 1)
// carries one PDU byte. Encoded frame bytes leave on frm, one per beat, with
// end_of_frame on the last byte of a frame and end_of_run on the last byte that an
// input beat caused. The frame_mode register (APB, address 0) selects RTU, TCP or
// ASCII and is read when each beat is accepted.
// The front stage updates CRC, LRC and the byte count in the cycle a beat is
// accepted and queues a job. The back stage emits one byte per cycle, while frm is
// ready, from the job at the head of the queue into an output register, so the
// first byte of a beat is registered in the queue and then in the output register.
// A beat causes 1 to 7 output bytes; data beats with no open frame cause nothing
// and are accepted without queuing a job. Sustained throughput is one frame byte
// per cycle while frm is ready. When frm stalls, the output register holds, the queue
// fills and req.ready drops; the input side runs on until the queue is full.
// Reset empties the queue and the output register, closes any open frame and sets
// frame_mode to RTU.
module modbus_frame_encoder
  import mfe_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  mfe_in_if.sink             req,
  mfe_out_if.source          frm
);

  logic [1:0] frame_mode;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       head;
  q_stat_t    q_stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_FRAME_MODE) ? {30'd0, frame_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode <= FRAME_MODE_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_FRAME_MODE) begin
      frame_mode <= pwdata[1:0];
    end
  end

  mfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frame_mode (frame_mode),
    .req        (req),
    .q_stat     (q_stat),
    .push       (push),
    .push_job   (push_job)
  );

  mfe_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  mfe_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .frm    (frm)
  );

`ifndef SYNTH
  a_eof_ends_run: assert property (@(posedge clk) disable iff (rst)
    frm.valid && frm.end_of_frame |-> frm.end_of_run)
    else $error("end_of_frame without end_of_run");

  a_reset_idle: assert property (@(posedge clk) rst |=> !frm.valid)
    else $error("output valid right after reset");

  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");
`endif

endmodule

// ===== tb/sv/modbus_frame_encoder_tb.sv =====
`timescale 1ns / 1ps

module modbus_frame_encoder_tb;
  import mfe_pkg::*;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [PADDR_W-1:0] MODE_ADDR = {ADDR_FRAME_MODE, 2'b00};
  localparam int PREDICT = -1;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES = 16;
  localparam int LONG_HOLD = 60;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 50;
  localparam logic [1:0] MODE_ORDER [4] = '{MODE_RTU, MODE_TCP, MODE_ASCII, MODE_RESERVED};

  typedef enum logic {DO_CFG, DO_BEAT} row_kind_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  station_id;
    logic [15:0] transaction_id;
    logic [7:0]  pdu_length;
    logic [7:0]  data_byte;
  } beat_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
    logic       end_of_run;
  } frame_out_t;

  typedef struct packed {
    int          n;
    logic [55:0] res;
    logic        eof;
  } exp_row_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  mode;
    logic        command;
    logic [7:0]  sid;
    logic [15:0] tid;
    logic [7:0]  len;
    logic [7:0]  dat;
    int          n;
    logic [55:0] res;
    logic        eof;
  } dir_row_t;

  localparam exp_row_t PREDICTED = '{PREDICT, 56'h0, 1'b0};

  // Typed results hold up to seven bytes, first byte in the top byte of res.
  localparam int DIR_N = 26;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{DO_BEAT, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h5A, 0, 56'h0, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_START, 8'h01, 16'h0000, 8'h01, 8'h00, PREDICT, 56'h0, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h03, PREDICT, 56'h0, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_START, 8'hFF, 16'hFFFF, 8'h00, 8'h00, PREDICT, 56'h0, 1'b0},
    '{DO_CFG, MODE_TCP, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h00, 0, 56'h0, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_START, 8'hFF, 16'hFFFF, 8'h00, 8'h00, 7, 56'hFFFF00000001FF, 1'b1},
    '{DO_BEAT, MODE_RTU, CMD_START, 8'h00, 16'h0000, 8'h02, 8'h00, 7, 56'h00000000000300, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'hFF, 1, 56'hFF000000000000, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_START, 8'h11, 16'h1234, 8'hFF, 8'h00, 7, 56'h12340000010011, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h00, 1, 56'h00000000000000, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_START, 8'h22, 16'hABCD, 8'hFD, 8'h00, 7, 56'hABCD000000FE22, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_START, 8'h33, 16'h0001, 8'h01, 8'h00, 7, 56'h00010000000233, 1'b0},
    '{DO_CFG, MODE_ASCII, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h00, 0, 56'h0, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'hAB, 6, 56'h414232320D0A00, 1'b1},
    '{DO_BEAT, MODE_RTU, CMD_START, 8'hAB, 16'h0000, 8'h02, 8'h00, 3, 56'h3A414200000000, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h00, 2, 56'h30300000000000, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'hFF, PREDICT, 56'h0, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h7E, 0, 56'h0, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_START, 8'h00, 16'h0000, 8'h00, 8'h00, 7, 56'h3A303030300D0A, 1'b1},
    '{DO_CFG, MODE_RESERVED, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h00, 0, 56'h0, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_START, 8'h5C, 16'hBEEF, 8'h02, 8'h00, PREDICT, 56'h0, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'hC3, PREDICT, 56'h0, 1'b0},
    '{DO_CFG, MODE_TCP, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h00, 0, 56'h0, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h81, 1, 56'h81000000000000, 1'b1},
    '{DO_CFG, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h00, 0, 56'h0, 1'b0},
    '{DO_BEAT, MODE_RTU, CMD_DATA, 8'h00, 16'h0000, 8'h00, 8'h42, 0, 56'h0, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  mfe_in_if  req ();
  mfe_out_if frm ();

  modbus_frame_encoder uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req),
    .frm     (frm)
  );

  always #2 clk = ~clk;

  logic [1:0]  cfg_mode = FRAME_MODE_RST;
  logic [15:0] crc_acc = CRC_INIT;
  logic [7:0]  lrc_acc = 8'h00;
  logic [7:0]  pdu_to_go = 8'h00;
  logic        frame_busy = 1'b0;

  frame_out_t beat_bytes [$];
  frame_out_t frame_due [$];
  exp_row_t   row_expect [$];

  int  errors = 0;
  int  src_gap_pct = 0;
  int  sink_stall_pct = 0;
  bit  hold_long = 1'b0;
  int  gen_to_go = 0;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h41 + 8'(nib) - 8'd10);
  endfunction

  function automatic void fold_byte(input logic [7:0] b);
    logic [15:0] c;
    c = crc_acc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    crc_acc = c;
    lrc_acc = lrc_acc + b;
  endfunction

  function automatic void put(input logic [7:0] b, input logic eof);
    frame_out_t fo;
    fo.frame_byte = b;
    fo.end_of_frame = eof;
    fo.end_of_run = 1'b0;
    beat_bytes.push_back(fo);
  endfunction

  function automatic void put_hex(input logic [7:0] b, input logic eof);
    put(hex_ascii(b[7:4]), 1'b0);
    put(hex_ascii(b[3:0]), eof);
  endfunction

  function automatic void close_frame();
    if (cfg_mode == MODE_TCP) begin
      if (beat_bytes.size() > 0) beat_bytes[beat_bytes.size() - 1].end_of_frame = 1'b1;
    end else if (cfg_mode == MODE_ASCII) begin
      put_hex(8'h00 - lrc_acc, 1'b0);
      put(CHAR_CR, 1'b0);
      put(CHAR_LF, 1'b1);
    end else begin
      put(crc_acc[7:0], 1'b0);
      put(crc_acc[15:8], 1'b1);
    end
    frame_busy = 1'b0;
    pdu_to_go = 8'h00;
  endfunction

  function automatic void encode_beat(input beat_t b);
    logic [15:0] mbap_len;
    beat_bytes.delete();
    if (b.command == CMD_START) begin
      crc_acc = CRC_INIT;
      lrc_acc = 8'h00;
      fold_byte(b.station_id);
      case (cfg_mode)
        MODE_TCP: begin
          mbap_len = {8'h00, b.pdu_length} + 16'd1;
          put(b.transaction_id[15:8], 1'b0);
          put(b.transaction_id[7:0], 1'b0);
          put(BYTE_ZERO, 1'b0);
          put(BYTE_ZERO, 1'b0);
          put(mbap_len[15:8], 1'b0);
          put(mbap_len[7:0], 1'b0);
          put(b.station_id, 1'b0);
        end
        MODE_ASCII: begin
          put(CHAR_COLON, 1'b0);
          put_hex(b.station_id, 1'b0);
        end
        default: put(b.station_id, 1'b0);
      endcase
      pdu_to_go = b.pdu_length;
      frame_busy = 1'b1;
      if (b.pdu_length == 8'h00) close_frame();
    end else if (frame_busy) begin
      fold_byte(b.data_byte);
      if (cfg_mode == MODE_ASCII) put_hex(b.data_byte, 1'b0);
      else put(b.data_byte, 1'b0);
      pdu_to_go = pdu_to_go - 8'd1;
      if (pdu_to_go == 8'h00) close_frame();
    end
    if (beat_bytes.size() > 0) beat_bytes[beat_bytes.size() - 1].end_of_run = 1'b1;
  endfunction

  always @(posedge clk) begin : scoreboard
    beat_t      seen;
    exp_row_t   tx;
    frame_out_t fo;
    frame_out_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        seen.command = req.command;
        seen.station_id = req.station_id;
        seen.transaction_id = req.transaction_id;
        seen.pdu_length = req.pdu_length;
        seen.data_byte = req.data_byte;
        tx = (row_expect.size() > 0) ? row_expect.pop_front() : PREDICTED;
        encode_beat(seen);
        if (tx.n != PREDICT) begin
          beat_bytes.delete();
          for (int k = 0; k < tx.n; k++) begin
            fo.frame_byte = tx.res[55 - 8 * k -: 8];
            fo.end_of_frame = tx.eof && (k == tx.n - 1);
            fo.end_of_run = (k == tx.n - 1);
            beat_bytes.push_back(fo);
          end
        end
        foreach (beat_bytes[i]) frame_due.push_back(beat_bytes[i]);
      end
      if (frm.valid && frm.ready) begin
        if (frame_due.size() == 0) begin
          $error("unexpected frame beat: frame_byte %h", frm.frame_byte);
          errors++;
        end else begin
          want = frame_due.pop_front();
          if (frm.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %h, got %h", want.frame_byte, frm.frame_byte);
            errors++;
          end
          if (frm.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %b, got %b", want.end_of_frame, frm.end_of_frame);
            errors++;
          end
          if (frm.end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %b, got %b", want.end_of_run, frm.end_of_run);
            errors++;
          end
        end
      end
    end
  end

  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    frm.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = draw_gap();
      end
      frm.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_beat(input beat_t b, input exp_row_t tx);
    int gap;
    gap = ($urandom_range(0, 99) < src_gap_pct) ? draw_gap() : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    row_expect.push_back(tx);
    req.valid <= 1'b1;
    req.command <= b.command;
    req.station_id <= b.station_id;
    req.transaction_id <= b.transaction_id;
    req.pdu_length <= b.pdu_length;
    req.data_byte <= b.data_byte;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic drain_all(input int settle);
    req.valid <= 1'b0;
    while (frame_due.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    logic [31:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODE_ADDR;
    pwdata <= {30'd0, m};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_mode = m;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[1:0] !== m) begin
      $error("frame_mode: expected %0d, got %0d", m, rd[1:0]);
      errors++;
    end
  endtask

  function automatic logic [7:0] pick_pdu_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 8'h00;
    if (r < 6) return 8'($urandom_range(128, 255));
    if (r < 20) return 8'($urandom_range(9, 40));
    return 8'($urandom_range(1, 8));
  endfunction

  // Mostly well-formed frames with random content; a few stray bytes and
  // restarts. A frame left open at the end of a phase continues in the next
  // phase's mode.
  task automatic random_phase(input int budget);
    int    taken;
    int    r;
    beat_t b;
    taken = 0;
    while (taken < budget) begin
      b.station_id = 8'($urandom_range(0, 255));
      b.transaction_id = 16'($urandom_range(0, 65535));
      b.pdu_length = 8'($urandom_range(0, 255));
      b.data_byte = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (gen_to_go == 0 && r < 6) begin
        b.command = CMD_DATA;
      end else if (gen_to_go == 0 || r < 4) begin
        b.command = CMD_START;
        b.pdu_length = pick_pdu_length();
        gen_to_go = b.pdu_length;
        taken++;
      end else begin
        b.command = CMD_DATA;
        gen_to_go--;
        taken++;
      end
      send_beat(b, PREDICTED);
    end
  endtask

  initial begin
    #3_000_000;
    $display("modbus_frame_encoder_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    beat_t    b;
    exp_row_t tx;
    req.valid = 1'b0;
    req.command = CMD_START;
    req.station_id = 8'h00;
    req.transaction_id = 16'h0000;
    req.pdu_length = 8'h00;
    req.data_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = MODE_ADDR;
    pwdata = 32'h0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_gap_pct = 25;
    sink_stall_pct = 25;
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].kind == DO_CFG) begin
        drain_all(SETTLE_CYCLES);
        write_mode(DIR_ROWS[i].mode);
      end else begin
        b.command = DIR_ROWS[i].command;
        b.station_id = DIR_ROWS[i].sid;
        b.transaction_id = DIR_ROWS[i].tid;
        b.pdu_length = DIR_ROWS[i].len;
        b.data_byte = DIR_ROWS[i].dat;
        tx.n = DIR_ROWS[i].n;
        tx.res = DIR_ROWS[i].res;
        tx.eof = DIR_ROWS[i].eof;
        send_beat(b, tx);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_all(SETTLE_CYCLES);
      write_mode((p < 4) ? MODE_ORDER[p] : MODE_ORDER[$urandom_range(0, 3)]);
      if (p == 0) begin
        src_gap_pct = 0;
        sink_stall_pct = 0;
      end else if (p == 1) begin
        src_gap_pct = 0;
        sink_stall_pct = 10;
        hold_long = 1'b1;
      end else begin
        src_gap_pct = $urandom_range(5, 50);
        sink_stall_pct = $urandom_range(5, 50);
      end
      random_phase(PHASE_ITEMS);
    end

    drain_all(END_CYCLES);
    if (errors == 0) begin
      $display("modbus_frame_encoder_tb: PASS");
    end else begin
      $display("modbus_frame_encoder_tb: FAIL");
    end
    $finish;
  end

endmodule
